FILE: design/psvm_pkg.sv
// Package for the PCM sample voice mixer: widths, constants, tables and helpers.
// No dependencies.
package psvm_pkg;

	localparam int SLOT_COUNT_DEF  = 16;
	localparam int SLOT_DEPTH_DEF  = 4096;
	localparam int VOICE_COUNT_DEF = 16;

	localparam logic [17:0] RATE_RESET = 18'd44100;
	localparam logic [17:0] RATE_MIN   = 18'd8000;

	localparam logic signed [18:0] MIX_MAX = 19'sd262143;
	localparam logic signed [18:0] MIX_MIN = -19'sd262144;

	localparam logic [23:0] STEP_MAX  = 24'hFFFFFF;
	localparam logic [23:0] STEP_ZERO = 24'h010000;

	typedef enum logic [1:0] {
		MODE_LOAD    = 2'd0,
		MODE_INFO    = 2'd1,
		MODE_TRIGGER = 2'd2,
		MODE_TICK    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_EMPTY   = 2'd1,
		ST_NO_FREE = 2'd2
	} status_t;

	function automatic logic [16:0] semitone(input logic [3:0] s);
		logic [16:0] r;
		unique case (s)
			4'd0:  r = 17'd65536;
			4'd1:  r = 17'd69433;
			4'd2:  r = 17'd73562;
			4'd3:  r = 17'd77936;
			4'd4:  r = 17'd82570;
			4'd5:  r = 17'd87480;
			4'd6:  r = 17'd92682;
			4'd7:  r = 17'd98193;
			4'd8:  r = 17'd104032;
			4'd9:  r = 17'd110218;
			4'd10: r = 17'd116772;
			4'd11: r = 17'd123715;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

	// round(0.45*65536*x/127) for x in 0..127, exact
	// (147456*x + 317) / 635 by reciprocal: ceil(2^35/635) = 54109825
	function automatic logic [15:0] pan_gain(input logic [6:0] x);
		logic [24:0] n;
		logic [50:0] p;
		n = (25'(x) << 17) + (25'(x) << 14) + 25'd317;
		p = 51'(n) * 51'd54109825;
		return 16'(p >> 35);
	endfunction

endpackage

FILE: design/psvm_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module psvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

FILE: design/pcm_sample_voice_mixer.sv
// Sequence: load and info go from S_LOAD to S_DONE; trigger goes through S_TRIG, the 48-bit
// bit-serial step divider and S_SCAN, or to S_DONE when refused; tick checks each voice in
// turn and, for a playing one, reads twice on the single RAM port, interpolates, makes two
// multiplier passes and advances. One transaction in process at a time; the next is taken
// once the sequencer is idle, and a result not yet taken holds the next one in S_DONE.
// Reset (arst_n low): all voices idle, slot counts and rates zero, output_rate 44100.
// Sample memory contents are undefined until written.
module pcm_sample_voice_mixer
	import psvm_pkg::*;
#(
	parameter int VOICE_COUNT = VOICE_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [17:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [3:0]         slot,
	input  logic [11:0]        sample_address,
	input  logic signed [15:0] sample_value,
	input  logic [12:0]        slot_length,
	input  logic [17:0]        slot_rate,
	input  logic [6:0]         note,
	input  logic [6:0]         pan_position,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [18:0] left_mix,
	output logic signed [18:0] right_mix,
	output logic [4:0]         active_voices,
	output logic [1:0]         status
);
	localparam int SLOT_COUNT = SLOT_COUNT_DEF;
	localparam int SLOT_DEPTH = SLOT_DEPTH_DEF;
	localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int DW  = $clog2(SLOT_DEPTH);
	localparam int CW  = DW + 1;
	localparam int VW  = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
	localparam int VCW = $clog2(VOICE_COUNT + 1);
	localparam int AW  = SW + DW;
	localparam int PW  = CW + 16;
	localparam int MEMD = SLOT_COUNT * SLOT_DEPTH;
	localparam int MAW = $clog2(MEMD);
	localparam int NW  = 48;

	typedef enum logic [3:0] {
		S_IDLE, S_LOAD, S_TRIG, S_SCAN, S_DIV, S_TICK_CHK, S_RD0, S_RD1, S_INTP,
		S_MULL, S_MULR, S_ADV, S_DONE
	} state_t;

	state_t state_q;

	logic [17:0]           orate_q;
	logic [CW-1:0]         cnt_q  [SLOT_COUNT];
	logic [17:0]           srate_q[SLOT_COUNT];
	logic [VOICE_COUNT-1:0] busy_q;
	logic [SW-1:0]         vslot_q[VOICE_COUNT];
	logic [PW-1:0]         vpos_q [VOICE_COUNT];
	logic [23:0]           vstep_q[VOICE_COUNT];
	logic [15:0]           vgl_q  [VOICE_COUNT];
	logic [15:0]           vgr_q  [VOICE_COUNT];

	logic [1:0]            mode_q;
	logic [3:0]            slot_q;
	logic [11:0]           addr_q;
	logic [15:0]           sval_q;
	logic [12:0]           len_q;
	logic [17:0]           srin_q;
	logic [6:0]            note_q;
	logic [6:0]            pan_q;

	logic [VW-1:0]         vi_q;
	logic [NW-1:0]         num_q;
	logic [NW-1:0]         rem_q;
	logic [25:0]           den_q;
	logic [NW-1:0]         quo_q;
	logic [5:0]            bit_q;
	logic signed [15:0]    s0_q;
	logic signed [33:0]    v_q;
	logic signed [22:0]    accl_q;
	logic signed [22:0]    accr_q;

	logic                  ovalid_q;
	logic signed [18:0]    left_q;
	logic signed [18:0]    right_q;
	logic [VCW-1:0]        nact_q;
	logic [1:0]            stat_q;
	logic [1:0]            ostat_q;

	// memory port
	logic                  mem_we;
	logic [MAW-1:0]        mem_addr;
	logic [15:0]           mem_rdata;

	psvm_ram #(.WIDTH(16), .DEPTH(MEMD)) u_store (
		.clk  (clk),
		.we   (mem_we),
		.addr (mem_addr),
		.wdata(sval_q),
		.rdata(mem_rdata)
	);

	// current voice view
	logic [SW-1:0]  cv_slot;
	logic [CW-1:0]  cv_cnt;
	logic [PW-1:0]  cv_pos;
	logic [CW-1:0]  cv_p0;
	logic [CW-1:0]  cv_p1;
	logic           cv_end;
	logic [PW:0]    cv_next;
	logic [PW:0]    cv_lim;

	assign cv_slot = vslot_q[vi_q];
	assign cv_cnt  = cnt_q[cv_slot];
	assign cv_pos  = vpos_q[vi_q];
	assign cv_p0   = cv_pos[PW-1:16];
	assign cv_p1   = (cv_p0 + 1'b1 < cv_cnt) ? cv_p0 + 1'b1 : cv_p0;
	assign cv_lim  = {1'b0, cv_cnt, 16'd0};
	assign cv_end  = (cv_cnt == '0) || ({1'b0, cv_pos} >= cv_lim);
	assign cv_next = {1'b0, cv_pos} + (PW+1)'(vstep_q[vi_q]);

	always_comb begin
		mem_we   = 1'b0;
		mem_addr = MAW'({slot_q[SW-1:0], addr_q[DW-1:0]});
		unique case (state_q)
			S_LOAD: mem_we = (mode_q == MODE_LOAD) && (32'(slot_q) < SLOT_COUNT) &&
				(32'(addr_q) < SLOT_DEPTH);
			S_TICK_CHK:  mem_addr = MAW'({cv_slot, cv_p0[DW-1:0]});
			S_RD0, S_RD1: mem_addr = MAW'({cv_slot, cv_p1[DW-1:0]});
			default: ;
		endcase
	end

	// lowest idle voice
	logic [VW-1:0] free_idx;
	logic          free_any;
	always_comb begin
		free_idx = '0;
		free_any = 1'b0;
		for (int i = VOICE_COUNT - 1; i >= 0; i--)
			if (!busy_q[i]) begin
				free_idx = VW'(i);
				free_any = 1'b1;
			end
	end

	logic [VCW-1:0] busy_cnt;
	always_comb begin
		busy_cnt = '0;
		for (int i = 0; i < VOICE_COUNT; i++)
			busy_cnt = busy_cnt + VCW'(busy_q[i]);
	end

	// octave and semitone of the key: note/12 as (note*43)>>9, exact for 0..127
	logic [3:0]  nmod;
	logic [3:0]  noct;
	assign noct = 4'((13'(note_q) * 13'd43) >> 9);
	assign nmod = 4'(note_q - 7'(noct) * 7'd12);

	logic [NW-1:0] rem_sh;
	assign rem_sh = {rem_q[NW-2:0], num_q[NW-1]};

	logic signed [49:0] prod;
	logic signed [16:0] mul_b;
	logic signed [33:0] mul_a;
	always_comb begin
		mul_a = v_q;
		mul_b = (state_q == S_MULR) ? $signed({1'b0, vgr_q[vi_q]})
		                            : $signed({1'b0, vgl_q[vi_q]});
	end
	assign prod = 50'(mul_a) * 50'(mul_b);

	logic signed [18:0] satl, satr;
	always_comb begin
		satl = (accl_q > 23'(MIX_MAX)) ? MIX_MAX : (accl_q < 23'(MIX_MIN)) ? MIX_MIN : accl_q[18:0];
		satr = (accr_q > 23'(MIX_MAX)) ? MIX_MAX : (accr_q < 23'(MIX_MIN)) ? MIX_MIN : accr_q[18:0];
	end

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) && !ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			orate_q  <= RATE_RESET;
			busy_q   <= '0;
			ovalid_q <= 1'b0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				cnt_q[i]   <= '0;
				srate_q[i] <= '0;
			end
		end else begin
			if (ovalid_q && out_ready && state_q != S_DONE)
				ovalid_q <= 1'b0;
			if (cfg_valid && cfg_ready)
				orate_q <= cfg_data;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						mode_q <= mode; slot_q <= slot; addr_q <= sample_address;
						sval_q <= sample_value; len_q <= slot_length; srin_q <= slot_rate;
						note_q <= note; pan_q <= pan_position;
						stat_q <= ST_OK; accl_q <= '0; accr_q <= '0; vi_q <= '0;
						unique case (mode_t'(mode))
							MODE_LOAD:    state_q <= S_LOAD;
							MODE_INFO:    state_q <= S_LOAD;
							MODE_TRIGGER: state_q <= S_TRIG;
							MODE_TICK:    state_q <= S_TICK_CHK;
						endcase
					end
				end
				S_LOAD: begin
					if (mode_q == MODE_INFO && 32'(slot_q) < SLOT_COUNT) begin
						cnt_q[slot_q[SW-1:0]]   <= (32'(len_q) > SLOT_DEPTH) ?
							CW'(SLOT_DEPTH) : CW'(len_q);
						srate_q[slot_q[SW-1:0]] <= srin_q;
					end
					state_q <= S_DONE;
				end
				S_TRIG: begin
					if (32'(slot_q) >= SLOT_COUNT || cnt_q[slot_q[SW-1:0]] == '0 ||
					    srate_q[slot_q[SW-1:0]] < RATE_MIN) begin
						stat_q  <= ST_EMPTY;
						state_q <= S_DONE;
					end else if (!free_any) begin
						stat_q  <= ST_NO_FREE;
						state_q <= S_DONE;
					end else begin
						vi_q    <= free_idx;
						num_q   <= NW'(NW'(srate_q[slot_q[SW-1:0]]) * NW'(semitone(nmod))
						           << ((noct >= 4'd5) ? (noct - 4'd5) : 4'd0));
						den_q   <= 26'(orate_q < RATE_MIN ? RATE_RESET : orate_q)
						           << ((noct < 4'd5) ? (4'd5 - noct) : 4'd0);
						rem_q   <= '0;
						quo_q   <= '0;
						bit_q   <= 6'(NW - 1);
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					num_q <= {num_q[NW-2:0], 1'b0};
					if (rem_sh >= NW'(den_q)) begin
						rem_q <= rem_sh - NW'(den_q);
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
					if (bit_q == '0)
						state_q <= S_SCAN;
					else
						bit_q <= bit_q - 1'b1;
				end
				S_SCAN: begin
					busy_q[vi_q]  <= 1'b1;
					vslot_q[vi_q] <= slot_q[SW-1:0];
					vpos_q[vi_q]  <= '0;
					vstep_q[vi_q] <= (quo_q > NW'(STEP_MAX)) ? STEP_MAX :
					                 (quo_q == '0) ? STEP_ZERO : quo_q[23:0];
					vgl_q[vi_q]   <= pan_gain(7'd127 - pan_q);
					vgr_q[vi_q]   <= pan_gain(pan_q);
					state_q       <= S_DONE;
				end
				S_TICK_CHK: begin
					if (!busy_q[vi_q] || cv_end) begin
						busy_q[vi_q] <= 1'b0;
						if (32'(vi_q) == VOICE_COUNT - 1)
							state_q <= S_DONE;
						else
							vi_q <= vi_q + 1'b1;
					end else
						state_q <= S_RD0;
				end
				S_RD0: begin
					s0_q    <= mem_rdata;
					state_q <= S_RD1;
				end
				S_RD1: state_q <= S_INTP;
				S_INTP: begin
					v_q <= 34'(s0_q) * $signed({1'b0, 17'(18'h10000 - 18'(cv_pos[15:0]))})
					       + 34'($signed(mem_rdata)) * $signed({1'b0, cv_pos[15:0]});
					state_q <= S_MULL;
				end
				S_MULL: begin
					accl_q  <= accl_q + 23'(prod >>> 32);
					state_q <= S_MULR;
				end
				S_MULR: begin
					accr_q  <= accr_q + 23'(prod >>> 32);
					state_q <= S_ADV;
				end
				S_ADV: begin
					vpos_q[vi_q] <= cv_next[PW-1:0];
					if (cv_next >= cv_lim)
						busy_q[vi_q] <= 1'b0;
					if (32'(vi_q) == VOICE_COUNT - 1)
						state_q <= S_DONE;
					else begin
						vi_q    <= vi_q + 1'b1;
						state_q <= S_TICK_CHK;
					end
				end
				S_DONE: begin
					if (!ovalid_q || out_ready) begin
						ovalid_q <= 1'b1;
						left_q   <= (mode_q == MODE_TICK) ? satl : '0;
						right_q  <= (mode_q == MODE_TICK) ? satr : '0;
						nact_q   <= busy_cnt;
						ostat_q  <= stat_q;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid     = ovalid_q;
	assign left_mix      = left_q;
	assign right_mix     = right_q;
	assign active_voices = 5'(nact_q);
	assign status        = ostat_q;

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == S_IDLE) else $error("ready outside idle");
	a_stat_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(ovalid_q && mode_q == MODE_TICK) |-> stat_q == ST_OK) else $error("tick status");
	a_busy_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		32'(busy_cnt) <= VOICE_COUNT) else $error("busy count");
endmodule

FILE: tb/pcm_sample_voice_mixer_checker.sv
`timescale 1ns / 100ps
// Checker for the PCM sample voice mixer: watches the config, input and result channels,
// keeps its own model of slots, voices and mix, and compares each result. Uses psvm_pkg.
module pcm_sample_voice_mixer_checker
	import psvm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [17:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [3:0]         slot,
	input  logic [11:0]        sample_address,
	input  logic signed [15:0] sample_value,
	input  logic [12:0]        slot_length,
	input  logic [17:0]        slot_rate,
	input  logic [6:0]         note,
	input  logic [6:0]         pan_position,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [18:0] left_mix,
	input  logic signed [18:0] right_mix,
	input  logic [4:0]         active_voices,
	input  logic [1:0]         status,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic signed [18:0] left;
		logic signed [18:0] right;
		logic [4:0]         voices;
		status_t            st;
	} frame_t;

	localparam int FIFO_DEPTH = 8;

	frame_t exp_fifo[FIFO_DEPTH];
	int     wr_n;
	int     rd_n;

	logic [17:0]        out_rate;
	logic signed [15:0] samples[SLOT_COUNT_DEF * SLOT_DEPTH_DEF];
	logic [12:0]        slot_count[SLOT_COUNT_DEF];
	logic [17:0]        slot_src[SLOT_COUNT_DEF];
	logic               v_busy[VOICE_COUNT_DEF];
	logic [3:0]         v_slot[VOICE_COUNT_DEF];
	logic [28:0]        v_pos[VOICE_COUNT_DEF];
	logic [23:0]        v_step[VOICE_COUNT_DEF];
	logic [15:0]        v_gl[VOICE_COUNT_DEF];
	logic [15:0]        v_gr[VOICE_COUNT_DEF];

	assign pending = wr_n - rd_n;

	task automatic report(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic logic [23:0] pitch_step(input logic [17:0] src, input logic [6:0] key);
		logic [17:0] r;
		int          oct;
		logic [63:0] num, den, q;
		r = (out_rate < RATE_MIN) ? RATE_RESET : out_rate;
		oct = int'(key / 12) - 5;
		num = 64'(src) * 64'(semitone(4'(key % 12)));
		den = 64'(r);
		if (oct >= 0) num = num << oct;
		else den = den << (-oct);
		q = num / den;
		if (q > 64'(STEP_MAX)) q = 64'(STEP_MAX);
		if (q == 0) q = 64'(STEP_ZERO);
		return q[23:0];
	endfunction

	function automatic logic [15:0] gain_of(input int x);
		return 16'((147456 * x + 317) / 635);
	endfunction

	function automatic longint floor32(input longint v);
		return v >>> 32;
	endfunction

	function automatic logic signed [18:0] clip(input longint v);
		if (v > MIX_MAX) return MIX_MAX;
		if (v < MIX_MIN) return MIX_MIN;
		return 19'(v);
	endfunction

	task automatic predict_item();
		frame_t f;
		longint sl, sr, v;
		int     i, p0, p1, fr, cnt, n;
		f = '0;
		f.st = ST_OK;
		sl = 0;
		sr = 0;
		case (mode_t'(mode))
			MODE_LOAD:
				samples[int'(slot) * SLOT_DEPTH_DEF + int'(sample_address)] = sample_value;
			MODE_INFO: begin
				slot_count[slot] = (slot_length > 13'(SLOT_DEPTH_DEF)) ?
					13'(SLOT_DEPTH_DEF) : slot_length;
				slot_src[slot] = slot_rate;
			end
			MODE_TRIGGER: begin
				if (slot_count[slot] == 0 || slot_src[slot] < RATE_MIN) begin
					f.st = ST_EMPTY;
				end else begin
					for (i = 0; i < VOICE_COUNT_DEF; i++)
						if (!v_busy[i]) break;
					if (i >= VOICE_COUNT_DEF) begin
						f.st = ST_NO_FREE;
					end else begin
						v_busy[i] = 1'b1;
						v_slot[i] = slot;
						v_pos[i]  = '0;
						v_step[i] = pitch_step(slot_src[slot], note);
						v_gl[i]   = gain_of(127 - int'(pan_position));
						v_gr[i]   = gain_of(int'(pan_position));
					end
				end
			end
			MODE_TICK: begin
				for (i = 0; i < VOICE_COUNT_DEF; i++) begin
					if (!v_busy[i]) continue;
					cnt = int'(slot_count[v_slot[i]]);
					if (cnt == 0 || longint'(v_pos[i]) >= (longint'(cnt) << 16)) begin
						v_busy[i] = 1'b0;
						continue;
					end
					p0 = int'(v_pos[i] >> 16);
					p1 = (p0 + 1 < cnt) ? p0 + 1 : p0;
					fr = int'(v_pos[i][15:0]);
					v = longint'(samples[int'(v_slot[i]) * SLOT_DEPTH_DEF + p0]) * (65536 - fr)
					  + longint'(samples[int'(v_slot[i]) * SLOT_DEPTH_DEF + p1]) * fr;
					sl += floor32(v * longint'(v_gl[i]));
					sr += floor32(v * longint'(v_gr[i]));
					v_pos[i] = v_pos[i] + 29'(v_step[i]);
					if (longint'(v_pos[i]) >= (longint'(cnt) << 16)) v_busy[i] = 1'b0;
				end
				f.left  = clip(sl);
				f.right = clip(sr);
			end
		endcase
		n = 0;
		for (i = 0; i < VOICE_COUNT_DEF; i++)
			if (v_busy[i]) n++;
		f.voices = 5'(n);
		exp_fifo[wr_n % FIFO_DEPTH] = f;
		wr_n++;
	endtask

	initial begin
		errors = 0;
		wr_n = 0;
		rd_n = 0;
		out_rate = RATE_RESET;
		for (int i = 0; i < SLOT_COUNT_DEF * SLOT_DEPTH_DEF; i++) samples[i] = '0;
		for (int i = 0; i < SLOT_COUNT_DEF; i++) begin
			slot_count[i] = '0;
			slot_src[i] = '0;
		end
		for (int i = 0; i < VOICE_COUNT_DEF; i++) begin
			v_busy[i] = 1'b0;
			v_slot[i] = '0;
			v_pos[i] = '0;
			v_step[i] = '0;
			v_gl[i] = '0;
			v_gr[i] = '0;
		end
	end

	always @(posedge clk) begin
		frame_t e;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (wr_n == rd_n) begin
					report("unexpected transaction", 0, 0);
				end else begin
					e = exp_fifo[rd_n % FIFO_DEPTH];
					rd_n++;
					if (left_mix !== e.left) report("left_mix", left_mix, e.left);
					if (right_mix !== e.right) report("right_mix", right_mix, e.right);
					if (active_voices !== e.voices)
						report("active_voices", active_voices, e.voices);
					if (status !== e.st) report("status", status, e.st);
				end
			end
			if (cfg_valid && cfg_ready) out_rate = cfg_data;
			if (in_valid && in_ready) predict_item();
		end
	end

endmodule

FILE: tb/pcm_sample_voice_mixer_tb.sv
`timescale 1ns / 100ps
// Testbench top for the PCM sample voice mixer: clock, reset, stimulus and verdict.
// Depends on psvm_pkg, pcm_sample_voice_mixer and pcm_sample_voice_mixer_checker.
module pcm_sample_voice_mixer_tb
	import psvm_pkg::*;
();

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [17:0]        cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [1:0]         mode = MODE_LOAD;
	logic [3:0]         slot = '0;
	logic [11:0]        sample_address = '0;
	logic signed [15:0] sample_value = '0;
	logic [12:0]        slot_length = '0;
	logic [17:0]        slot_rate = '0;
	logic [6:0]         note = '0;
	logic [6:0]         pan_position = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic signed [18:0] left_mix;
	logic signed [18:0] right_mix;
	logic [4:0]         active_voices;
	logic [1:0]         status;
	int                 errors;
	int                 pending;
	longint             cycles = 0;
	bit                 hold_off = 1'b0;
	int                 written[16];

	localparam longint CYCLE_LIMIT = 3000000;

	pcm_sample_voice_mixer DUT (.*);
	pcm_sample_voice_mixer_checker checker_i (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout");
			$display("FAIL pcm_sample_voice_mixer");
			$finish;
		end
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(20, 120);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 4);
	endfunction

	// receiver side: random stalls, or a long hold-off when asked
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			if (hold_off) begin
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_off = 1'b0;
			end else begin
				g = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
				if (g > 0) begin
					out_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
		end
	end

	// valid stays high after the accepting edge until the next transaction or a gap replaces it
	task automatic send(input mode_t m, input int s, input int a, input int v, input int l,
		input int r, input int k, input int p);
		int g;
		g = pick_gap();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid       <= 1'b1;
		mode           <= m;
		slot           <= 4'(s);
		sample_address <= 12'(a);
		sample_value   <= 16'(v);
		slot_length    <= 13'(l);
		slot_rate      <= 18'(r);
		note           <= 7'(k);
		pan_position   <= 7'(p);
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_rate(input int r);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= 18'(r);
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// loads only where sample reads can reach, so unwritten memory is never read
	task automatic fill_slot(input int s, input int len, input int r);
		for (int a = written[s]; a < len; a++)
			send(MODE_LOAD, s, a, $urandom, $urandom, $urandom, $urandom, $urandom);
		if (len > written[s]) written[s] = len;
		send(MODE_INFO, s, $urandom, $urandom, len, r, $urandom, $urandom);
	endtask

	task automatic random_item();
		int c, s;
		c = $urandom_range(0, 99);
		s = $urandom_range(0, 15);
		if (c < 15) begin
			send(MODE_LOAD, s, $urandom_range(0, 4095), $urandom, $urandom, $urandom,
				$urandom, $urandom);
			if (written[s] == 0) written[s] = 0;
		end else if (c < 22) begin
			fill_slot(s, $urandom_range(0, 12), ($urandom_range(0, 5) == 0) ?
				$urandom_range(0, 8000) : $urandom_range(8000, 192000));
		end else if (c < 24) begin
			send(MODE_INFO, s, $urandom, $urandom, 0, $urandom, $urandom, $urandom);
		end else if (c < 50) begin
			send(MODE_TRIGGER, s, $urandom, $urandom, $urandom, $urandom,
				$urandom_range(0, 127), $urandom_range(0, 127));
		end else begin
			send(MODE_TICK, s, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	initial begin
		for (int i = 0; i < 16; i++) written[i] = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, unusable slots, allocation overflow, end of sample
		send(MODE_TRIGGER, 3, 0, 0, 0, 0, 60, 64);
		fill_slot(0, 4, 8000);
		send(MODE_LOAD, 0, 1, -32768, 0, 0, 0, 0);
		send(MODE_LOAD, 0, 2, 32767, 0, 0, 0, 0);
		send(MODE_INFO, 1, 0, 0, 3, 7999, 0, 0);
		send(MODE_TRIGGER, 1, 0, 0, 0, 0, 60, 0);
		send(MODE_TRIGGER, 0, 0, 0, 0, 0, 0, 0);
		send(MODE_TRIGGER, 0, 0, 0, 0, 0, 127, 127);
		send(MODE_TRIGGER, 0, 0, 0, 0, 0, 60, 63);
		send(MODE_TICK, 0, 0, 0, 0, 0, 0, 0);
		send(MODE_TICK, 0, 0, 0, 0, 0, 0, 0);
		send(MODE_INFO, 2, 0, 0, 8191, 192000, 0, 0);
		written[2] = 4096;
		for (int i = 0; i < 17; i++) send(MODE_TRIGGER, 0, 0, 0, 0, 0, 60, i * 7);
		send(MODE_LOAD, 15, 4095, 32767, 0, 0, 0, 0);
		for (int i = 0; i < 6; i++) send(MODE_TICK, 0, 0, 0, 0, 0, 0, 0);

		// slot 2 claims full depth but is never written: shorten before use
		send(MODE_INFO, 2, 0, 0, 0, 0, 0, 0);
		written[2] = 0;
		for (int i = 0; i < 20; i++) send(MODE_TICK, 0, 0, 0, 0, 0, 0, 0);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_rate(8000);
				1: set_rate(192000);
				2: set_rate(0);
				3: set_rate(262143);
				default: set_rate($urandom_range(8000, 192000));
			endcase
			if (ph == 1) hold_off = 1'b1;
			for (int n = 0; n < 210; n++) random_item();
			if (ph == 2) drain();
		end

		drain();
		if (errors == 0)
			$display("PASS pcm_sample_voice_mixer");
		else
			$display("FAIL pcm_sample_voice_mixer");
		$finish;
	end

endmodule

FILE: pcm_sample_voice_mixer.f
design/psvm_pkg.sv
design/psvm_ram.sv
design/pcm_sample_voice_mixer.sv
tb/pcm_sample_voice_mixer_checker.sv
tb/pcm_sample_voice_mixer_tb.sv
